@@ hw/rtl/lkvc_pkg.sv @@
package lkvc_pkg;

  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  localparam int CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_HIT      = 2'd2,
    ST_MISS     = 2'd3
  } status_t;

  typedef struct packed {
    logic accept;
    logic match;
    logic update;
    logic load_out;
  } lkvc_cmd_t;

endpackage

@@ hw/rtl/lkvc_req_if.sv @@
interface lkvc_req_if #(
  parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
);
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

@@ hw/rtl/lkvc_rsp_if.sv @@
interface lkvc_rsp_if #(
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
);
  logic                  valid;
  logic                  ready;
  lkvc_pkg::status_t     status;
  logic [VALUE_BITS-1:0] found_value;

  modport source (output valid, output status, output found_value, input ready);
  modport sink   (input valid, input status, input found_value, output ready);
endinterface

@@ hw/rtl/lkvc_ram.sv @@
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/lkvc_ctrl.sv @@
module lkvc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output lkvc_pkg::lkvc_cmd_t cmd
);
  import lkvc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE,
    S_DONE
  } state_t;

  state_t state;
  logic   can_load;

  assign can_load = (state == S_DONE) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE) || can_load;

  always_comb begin
    cmd          = '0;
    cmd.accept   = in_valid && in_ready;
    cmd.match    = (state == S_MATCH);
    cmd.update   = (state == S_UPDATE);
    cmd.load_out = can_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (can_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (can_load) begin
            state <= in_valid ? S_MATCH : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/lkvc_datapath.sv @@
module lkvc_datapath #(
  parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lkvc_pkg::lkvc_cmd_t           cmd,
  input  logic                          cfg_we,
  input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_wdata,
  input  logic                          operation,
  input  logic [KEY_BITS-1:0]           key,
  input  logic [VALUE_BITS-1:0]         value,
  output lkvc_pkg::status_t             status,
  output logic [VALUE_BITS-1:0]         found_value
);
  import lkvc_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int RANK_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WIDE_W = (CAP_BITS > CNT_W) ? CAP_BITS : CNT_W;

  logic [CAP_BITS-1:0]   capacity;
  logic                  op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  logic [KEY_BITS-1:0]   keys  [ENTRIES];
  logic [RANK_W-1:0]     ranks [ENTRIES];
  logic [ENTRIES-1:0]    valid;
  logic [CNT_W-1:0]      count;

  logic [ENTRIES-1:0]    match_vec;
  logic [ENTRIES-1:0]    match_q;
  logic                  hit_q;
  logic [RANK_W-1:0]     hit_rank;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      victim_idx;
  logic [IDX_W-1:0]      free_idx;
  logic [IDX_W-1:0]      slot_idx;
  logic [CNT_W-1:0]      eff_cap;
  logic [WIDE_W-1:0]     cap_wide;
  logic                  full;
  logic                  insert_new;
  status_t               status_q;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_addr;
  logic [VALUE_BITS-1:0] ram_rdata;

  always_comb begin
    cap_wide = WIDE_W'(capacity);
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_wide > WIDE_W'(ENTRIES)) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_wide);
    end
  end

  assign full = (count >= eff_cap);

  always_comb begin
    hit_rank   = '0;
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid[i] && (keys[i] == key_q);
      if (match_q[i]) begin
        hit_rank = hit_rank | ranks[i];
        hit_idx  = hit_idx | IDX_W'(i);
      end
      if (valid[i] && (CNT_W'(ranks[i]) == count - CNT_W'(1))) begin
        victim_idx = victim_idx | IDX_W'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign insert_new = (op_q == OP_INSERT) && !hit_q;
  assign slot_idx   = full ? victim_idx : free_idx;
  assign ram_addr   = insert_new ? slot_idx : hit_idx;
  assign ram_we     = cmd.update && insert_new;

  lkvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_values (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (value_q),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q    <= operation;
      key_q   <= key;
      value_q <= value;
    end
    if (cmd.match) begin
      match_q <= match_vec;
      hit_q   <= |match_vec;
    end
    if (cmd.update) begin
      if (op_q == OP_FIND) begin
        status_q <= hit_q ? ST_HIT : ST_MISS;
      end else begin
        status_q <= hit_q ? ST_REJECTED : ST_INSERTED;
      end
      if (insert_new) begin
        keys[slot_idx] <= key_q;
      end
    end
    if (cmd.load_out) begin
      status      <= status_q;
      found_value <= (status_q == ST_HIT) ? ram_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      valid    <= '0;
      count    <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        ranks[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.update) begin
        if ((op_q == OP_FIND) && hit_q) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (match_q[i]) begin
              ranks[i] <= '0;
            end else if (valid[i] && (ranks[i] < hit_rank)) begin
              ranks[i] <= ranks[i] + RANK_W'(1);
            end
          end
        end else if (insert_new) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (IDX_W'(i) == slot_idx) begin
              valid[i] <= 1'b1;
              ranks[i] <= '0;
            end else if (valid[i]) begin
              ranks[i] <= ranks[i] + RANK_W'(1);
            end
          end
          if (!full) begin
            count <= count + CNT_W'(1);
          end
        end
      end
    end
  end

endmodule

@@ hw/rtl/lru_key_value_cache.sv @@
// fully associative key/value cache with lru replacement: an insert (operation 0) of a key
// already held returns status 1 and changes nothing, otherwise the entry is stored as most
// recent (status 0), evicting the least recent entry once the entry count has reached the
// capacity register (0 acts as 1, values above ENTRIES act as ENTRIES); a find (operation 1)
// returns status 2 with the value and makes the entry most recent, or status 3 with zero;
// each transaction passes through a parallel key compare, then a rank/entry update with the
// value ram access, then a load of the output register, which waits until the output
// register is free; the next request is accepted as the result is loaded, so transactions
// do not overlap; write capacity only while no transaction is in flight
module lru_key_value_cache #(
  parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  lkvc_req_if.sink                      req,
  lkvc_rsp_if.source                    rsp,
  input  logic                          cfg_we,
  input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_wdata
);
  import lkvc_pkg::*;

  lkvc_cmd_t cmd;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  lkvc_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .operation   (req.operation),
    .key         (req.key),
    .value       (req.value),
    .status      (rsp.status),
    .found_value (rsp.found_value)
  );

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int ENTRIES     = DEF_ENTRIES;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_LEN    = 60;
  localparam int PHASE_ITEMS = 84;

  typedef struct packed {
    logic                is_cfg;
    logic [CAP_BITS-1:0] cap;
    logic                op;
    logic [31:0]         key;
    logic [31:0]         val;
    logic                chk;
    status_t             st;
    logic [31:0]         fv;
  } step_row_t;

  typedef struct {
    status_t     st;
    logic [31:0] fv;
  } rsp_t;

  localparam int N_ROWS = 26;
  localparam step_row_t DIRECTED [N_ROWS] = '{
    // find right after reset
    '{1'b0, 5'd0,  OP_FIND,   32'h0000_0000, 32'h0000_0000, 1'b1, ST_MISS,     32'h0},
    // capacity one: the only entry is replaced
    '{1'b1, 5'd1,  OP_INSERT, 32'h0,         32'h0,         1'b0, ST_INSERTED, 32'h0},
    '{1'b0, 5'd0,  OP_INSERT, 32'h0000_00A1, 32'h0000_0000, 1'b1, ST_INSERTED, 32'h0},
    '{1'b0, 5'd0,  OP_INSERT, 32'h0000_00B2, 32'hDEAD_BEEF, 1'b1, ST_INSERTED, 32'h0},
    '{1'b0, 5'd0,  OP_FIND,   32'h0000_00A1, 32'h0000_0000, 1'b1, ST_MISS,     32'h0},
    '{1'b0, 5'd0,  OP_FIND,   32'h0000_00B2, 32'h1111_1111, 1'b1, ST_HIT,   32'hDEAD_BEEF},
    '{1'b0, 5'd0,  OP_INSERT, 32'h0000_00B2, 32'h0000_0001, 1'b1, ST_REJECTED, 32'h0},
    // capacity zero acts as one
    '{1'b1, 5'd0,  OP_INSERT, 32'h0,         32'h0,         1'b0, ST_INSERTED, 32'h0},
    '{1'b0, 5'd0,  OP_INSERT, 32'h0000_00C3, 32'h0000_0007, 1'b1, ST_INSERTED, 32'h0},
    '{1'b0, 5'd0,  OP_FIND,   32'h0000_00B2, 32'h0000_0000, 1'b1, ST_MISS,     32'h0},
    '{1'b0, 5'd0,  OP_FIND,   32'h0000_00C3, 32'h0000_0000, 1'b1, ST_HIT,      32'h7},
    // capacity above entries saturates
    '{1'b1, 5'd31, OP_INSERT, 32'h0,         32'h0,         1'b0, ST_INSERTED, 32'h0},
    '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_INSERTED, 32'h0},
    '{1'b0, 5'd0,  OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_INSERTED, 32'h0},
    '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0000, 32'h0000_0005, 1'b1, ST_REJECTED, 32'h0},
    '{1'b0, 5'd0,  OP_FIND,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_HIT,   32'hFFFF_FFFF},
    '{1'b0, 5'd0,  OP_FIND,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_HIT,      32'h0},
    '{1'b0, 5'd0,  OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, ST_INSERTED, 32'h0},
    '{1'b0, 5'd0,  OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, ST_INSERTED, 32'h0},
    '{1'b0, 5'd0,  OP_FIND,   32'hAAAA_AAAA, 32'h0000_0000, 1'b1, ST_HIT,   32'h5555_5555},
    // capacity lowered below the entry count
    '{1'b1, 5'd2,  OP_INSERT, 32'h0,         32'h0,         1'b0, ST_INSERTED, 32'h0},
    '{1'b0, 5'd0,  OP_INSERT, 32'h1234_5678, 32'h0000_0009, 1'b0, ST_INSERTED, 32'h0},
    '{1'b0, 5'd0,  OP_FIND,   32'h0000_00C3, 32'h0000_0000, 1'b0, ST_INSERTED, 32'h0},
    '{1'b0, 5'd0,  OP_FIND,   32'h5555_5555, 32'h0000_0000, 1'b0, ST_INSERTED, 32'h0},
    '{1'b1, 5'd16, OP_INSERT, 32'h0,         32'h0,         1'b0, ST_INSERTED, 32'h0},
    '{1'b0, 5'd0,  OP_FIND,   32'h1234_5678, 32'h0000_0000, 1'b0, ST_INSERTED, 32'h0}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CAP_BITS-1:0] cfg_wdata;

  lkvc_req_if req_if ();
  lkvc_rsp_if rsp_if ();

  lru_key_value_cache DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // cache image
  logic [31:0]         slot_key  [ENTRIES];
  logic [31:0]         slot_val  [ENTRIES];
  logic                slot_used [ENTRIES];
  int                  slot_age  [ENTRIES];
  int                  fill_count;
  logic [CAP_BITS-1:0] cap_reg;

  rsp_t pending_rsp [$];
  int   err_count;
  int   rsp_count;
  int   quiet_cycles;
  bit   idle_on;
  bit   hold_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic lru_apply(input logic op, input logic [31:0] k, input logic [31:0] v,
                           output status_t st, output logic [31:0] fv);
    int hit;
    int slot;
    int lim;
    int worst;
    int ecap;
    hit  = -1;
    slot = -1;
    st   = ST_INSERTED;
    fv   = '0;
    for (int i = 0; i < ENTRIES; i++)
      if (hit < 0 && slot_used[i] && slot_key[i] == k) hit = i;
    if (op == OP_FIND) begin
      if (hit < 0) begin
        st = ST_MISS;
      end else begin
        lim = slot_age[hit];
        for (int i = 0; i < ENTRIES; i++)
          if (slot_used[i] && slot_age[i] < lim) slot_age[i]++;
        slot_age[hit] = 0;
        st = ST_HIT;
        fv = slot_val[hit];
      end
    end else if (hit >= 0) begin
      st = ST_REJECTED;
    end else begin
      ecap = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg));
      if (fill_count >= ecap && fill_count > 0) begin
        worst = 0;
        for (int i = 0; i < ENTRIES; i++)
          if (slot_used[i] && (slot < 0 || slot_age[i] >= worst)) begin
            worst = slot_age[i];
            slot  = i;
          end
        slot_used[slot] = 1'b0;
      end else begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !slot_used[i]) slot = i;
        fill_count++;
      end
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i]) slot_age[i]++;
      slot_key[slot]  = k;
      slot_val[slot]  = v;
      slot_used[slot] = 1'b1;
      slot_age[slot]  = 0;
    end
  endtask

  task automatic send_item(input logic op, input logic [31:0] k, input logic [31:0] v,
                           input logic chk, input status_t st_t, input logic [31:0] fv_t);
    status_t     st_p;
    logic [31:0] fv_p;
    rsp_t        r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.key       <= k;
    req_if.value     <= v;
    do @(posedge clk); while (!req_if.ready);
    lru_apply(op, k, v, st_p, fv_p);
    r.st = chk ? st_t : st_p;
    r.fv = chk ? fv_t : fv_p;
    pending_rsp.push_back(r);
    @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] c);
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_wdata <= c;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we  <= 1'b0;
    cap_reg = c;
  endtask

  task automatic run_phase(input logic [CAP_BITS-1:0] c, input int n);
    logic [31:0] pool [$];
    int          ecap;
    int          r;
    logic        op;
    logic [31:0] k;
    write_capacity(c);
    ecap = (c == 0) ? 1 : ((c > ENTRIES) ? ENTRIES : int'(c));
    repeat (ecap + $urandom_range(1, 8)) pool.push_back($urandom);
    repeat (n) begin
      r  = $urandom_range(0, 99);
      op = (r < 50) ? OP_INSERT : OP_FIND;
      if (r % 10 == 0) k = $urandom;
      else k = pool[$urandom_range(0, pool.size() - 1)];
      send_item(op, k, $urandom, 1'b0, ST_INSERTED, 32'h0);
    end
  endtask

  initial begin
    logic [CAP_BITS-1:0] caps [9];
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_INSERT;
    req_if.key       = '0;
    req_if.value     = '0;
    err_count        = 0;
    fill_count       = 0;
    cap_reg          = CAP_RESET;
    idle_on          = 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_key[i]  = '0;
      slot_val[i]  = '0;
      slot_used[i] = 1'b0;
      slot_age[i]  = 0;
    end
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_cfg) write_capacity(DIRECTED[i].cap);
      else send_item(DIRECTED[i].op, DIRECTED[i].key, DIRECTED[i].val,
                     DIRECTED[i].chk, DIRECTED[i].st, DIRECTED[i].fv);
    end

    caps = '{5'd2, 5'd16, 5'd3, 5'd31, 5'd0, 5'd8, 5'd1, CAP_BITS'($urandom_range(4, 15)),
             5'd16};
    foreach (caps[i]) begin
      // last part runs without idling
      if (i == 8) idle_on = 1'b0;
      run_phase(caps[i], PHASE_ITEMS);
    end

    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // response side, including one long hold-off so the block backs up
  initial begin
    int hold_left;
    hold_left    = 0;
    hold_done    = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && rsp_count >= HOLD_AT) begin
        hold_done    = 1'b1;
        hold_left    = HOLD_LEN - 1;
        rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        hold_left    = $urandom_range(0, 3);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      rsp_count <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      rsp_count <= rsp_count + 1;
      if (pending_rsp.size() == 0) begin
        $error("unexpected transaction: status %0d found_value %h",
               rsp_if.status, rsp_if.found_value);
        err_count++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_if.status !== e.st) begin
          $error("status mismatch: expected %0d, actual %0d", e.st, rsp_if.status);
          err_count++;
        end
        if (rsp_if.found_value !== e.fv) begin
          $error("found_value mismatch: expected %h, actual %h", e.fv, rsp_if.found_value);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
